// ===== hdl/lfla_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lfla_pkg;

    localparam int C_DEPTH      = 64;
    localparam int C_TAG_BITS   = 16;
    localparam int C_VALUE_BITS = 32;

    typedef enum logic [2:0] {
        REQ_ALLOC = 3'd0,
        REQ_FREE  = 3'd1,
        REQ_COUNT = 3'd2,
        REQ_QUERY = 3'd3,
        REQ_WRITE = 3'd4,
        REQ_READ  = 3'd5
    } t_req_code;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OOM     = 2'd1;
    localparam logic [1:0] ST_NO_TAG  = 2'd2;
    localparam logic [1:0] ST_PENDING = 2'd3;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_ALLOC,
        S_FCHK,
        S_FWALK,
        S_TAG
    } t_state;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [5:0]         addr;
        logic [15:0]        tag;
        logic signed [31:0] value;
        logic               last_tag;
    } t_req;

    typedef struct packed {
        logic [5:0]         head_addr;
        logic signed [31:0] read_value;
        logic [6:0]         free_count;
        logic [6:0]         used_count;
        logic               is_free;
        logic [1:0]         status;
    } t_rsp;

endpackage
`default_nettype wire

// ===== hdl/linked_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Count, rejected and out-of-range requests answer in the cycle after start; an
// alloc beat that finds a free node answers from S_ALLOC; free, query and tag
// walks read one node per cycle and answer when the walk ends.
// Throughput: one request at a time; busy is high while a walk runs. The result
// strobe lasts one cycle and cannot be stalled. Reset: synchronous, active low,
// then a sweep over every entry initializes links and values while busy stays high.
module linked_free_list_allocator_core #(
    parameter int DEPTH      = lfla_pkg::C_DEPTH,
    parameter int TAG_BITS   = lfla_pkg::C_TAG_BITS,
    parameter int VALUE_BITS = lfla_pkg::C_VALUE_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire lfla_pkg::t_req i_req,
    output logic               busy,
    output logic               o_done,
    output lfla_pkg::t_rsp     o_rsp
);

    import lfla_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] NIL = LW'(DEPTH);

    // control state
    t_state           r_state, n_state;
    logic [LW-1:0]    r_free_head, n_free_head;
    logic [LW-1:0]    r_free_total, n_free_total;
    logic             r_open, n_open;
    logic [AW-1:0]    r_first, n_first;
    logic [AW-1:0]    r_ix, n_ix;
    logic             r_done, n_done;
    // walk datapath
    t_req             r_req, n_req;
    logic [LW-1:0]    r_x, n_x;
    logic [LW-1:0]    r_steps, n_steps;
    logic [LW:0]      r_len, n_len;
    t_rsp             r_rsp, n_rsp;

    // memory ports
    logic [AW-1:0]         rd_addr;
    logic                  link_we, tag_we, val_we;
    logic [AW-1:0]         link_wa, tag_wa, val_wa;
    logic [LW-1:0]         link_wd;
    logic [TAG_BITS-1:0]   tag_wd;
    logic [VALUE_BITS-1:0] val_wd;
    logic [LW-1:0]         q_link;
    logic [TAG_BITS-1:0]   q_tag;
    logic [VALUE_BITS-1:0] q_val;

    // helpers
    logic                  in_ok, head_null, hit, tag_hit;
    logic [LW-1:0]         a_ext, nx, ns;
    logic [LW+1:0]         sum;

    lfla_mem #(
        .DEPTH      (DEPTH),
        .TAG_BITS   (TAG_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_link_we (link_we),
        .i_link_wa (link_wa),
        .i_link_wd (link_wd),
        .i_tag_we  (tag_we),
        .i_tag_wa  (tag_wa),
        .i_tag_wd  (tag_wd),
        .i_val_we  (val_we),
        .i_val_wa  (val_wa),
        .i_val_wd  (val_wd),
        .o_link    (q_link),
        .o_tag     (q_tag),
        .o_val     (q_val)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_free_head  <= '0;
            r_free_total <= LW'(DEPTH);
            r_open       <= 1'b0;
            r_first      <= '0;
            r_ix         <= '0;
            r_done       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_free_total <= n_free_total;
            r_open       <= n_open;
            r_first      <= n_first;
            r_ix         <= n_ix;
            r_done       <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_x     <= n_x;
        r_steps <= n_steps;
        r_len   <= n_len;
        r_rsp   <= n_rsp;
    end

    always_comb begin
        // live-beat and walk helpers
        in_ok     = (32'(i_req.addr) < DEPTH);
        head_null = !(r_free_head < NIL);
        a_ext     = LW'(r_req.addr);
        hit       = (r_x == a_ext);
        tag_hit   = (q_tag == TAG_BITS'(r_req.tag));
        nx        = q_link;
        ns        = r_steps + 1'b1;
        sum       = (LW+2)'(r_free_total) + (LW+2)'(r_len);

        n_state      = r_state;
        n_free_head  = r_free_head;
        n_free_total = r_free_total;
        n_open       = r_open;
        n_first      = r_first;
        n_ix         = r_ix;
        n_done       = 1'b0;
        n_req        = r_req;
        n_x          = r_x;
        n_steps      = r_steps;
        n_len        = r_len;
        n_rsp        = '0;

        rd_addr = AW'(r_x);
        link_we = 1'b0;
        link_wa = AW'(r_x);
        link_wd = r_free_head;
        tag_we  = 1'b0;
        tag_wa  = AW'(r_x);
        tag_wd  = TAG_BITS'(r_req.tag);
        val_we  = 1'b0;
        val_wa  = AW'(r_x);
        val_wd  = VALUE_BITS'(r_req.value);

        case (r_state)
            S_INIT: begin
                // entry i links to i+1; the last one lands on null
                link_we = 1'b1;
                link_wa = r_ix;
                link_wd = LW'(r_ix) + 1'b1;
                val_we  = 1'b1;
                val_wa  = r_ix;
                val_wd  = '0;
                n_ix    = r_ix + 1'b1;
                if (r_ix == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_steps = '0;
                    n_len   = (LW+1)'(1);
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (head_null) begin
                            // out of memory: close the run, report its head
                            n_rsp.head_addr = r_open ? 6'(r_first) : 6'd0;
                            n_rsp.status    = ST_OOM;
                            n_open          = 1'b0;
                            n_done          = 1'b1;
                        end else begin
                            rd_addr = AW'(r_free_head);
                            n_x     = r_free_head;
                            n_state = S_ALLOC;
                        end
                    end else if (r_open) begin
                        n_rsp.status = ST_PENDING;
                        n_done       = 1'b1;
                    end else begin
                        case (i_req.req_type)
                            REQ_FREE: begin
                                if (!in_ok) begin
                                    n_done = 1'b1;
                                end else if (head_null) begin
                                    // nothing free: go straight to the chain walk
                                    rd_addr = AW'(i_req.addr);
                                    n_x     = LW'(i_req.addr);
                                    n_state = S_FWALK;
                                end else begin
                                    rd_addr = AW'(r_free_head);
                                    n_x     = r_free_head;
                                    n_state = S_FCHK;
                                end
                            end
                            REQ_QUERY: begin
                                if (!in_ok || head_null) begin
                                    n_done = 1'b1;
                                end else begin
                                    rd_addr = AW'(r_free_head);
                                    n_x     = r_free_head;
                                    n_state = S_FCHK;
                                end
                            end
                            REQ_WRITE, REQ_READ: begin
                                if (!in_ok) begin
                                    n_rsp.status = (i_req.req_type == REQ_READ) ?
                                                   ST_NO_TAG : ST_OK;
                                    n_done       = 1'b1;
                                end else begin
                                    rd_addr = AW'(i_req.addr);
                                    n_x     = LW'(i_req.addr);
                                    n_state = S_TAG;
                                end
                            end
                            default: begin
                                n_done = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_ALLOC: begin
                // q_link is the successor of the node being taken
                tag_we      = 1'b1;
                n_free_head = q_link;
                if (r_free_total != '0) begin
                    n_free_total = r_free_total - 1'b1;
                end
                n_rsp.head_addr = r_open ? 6'(r_first) : 6'(AW'(r_x));
                if (!r_open) begin
                    n_first = AW'(r_x);
                end
                if (r_req.last_tag) begin
                    link_we      = 1'b1;
                    link_wd      = NIL;
                    n_open       = 1'b0;
                    n_rsp.status = ST_OK;
                end else begin
                    n_open       = 1'b1;
                    n_rsp.status = ST_PENDING;
                end
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_FCHK: begin
                // walk the free list looking for the request address
                if (!hit && (nx < NIL) && (ns != LW'(DEPTH))) begin
                    rd_addr = AW'(nx);
                    n_x     = nx;
                    n_steps = ns;
                end else if (r_req.req_type == REQ_QUERY) begin
                    n_rsp.is_free = hit;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end else if (hit) begin
                    // freeing a free node: drop the request
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    rd_addr = AW'(r_req.addr);
                    n_x     = a_ext;
                    n_steps = '0;
                    n_len   = (LW+1)'(1);
                    n_state = S_FWALK;
                end
            end
            S_FWALK: begin
                if ((q_link < NIL) && (r_steps < LW'(DEPTH))) begin
                    rd_addr = AW'(q_link);
                    n_x     = q_link;
                    n_steps = ns;
                    n_len   = r_len + 1'b1;
                end else begin
                    if (!(q_link < NIL)) begin
                        // splice the chain in front of the free list
                        link_we      = 1'b1;
                        n_free_head  = a_ext;
                        n_free_total = (sum > (LW+2)'(DEPTH)) ? LW'(DEPTH) : LW'(sum);
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_TAG: begin
                if (tag_hit && (r_req.req_type == REQ_WRITE)) begin
                    val_we = 1'b1;
                end
                if (tag_hit && (r_req.req_type == REQ_READ)) begin
                    n_rsp.read_value = 32'(signed'(q_val));
                    n_done           = 1'b1;
                    n_state          = S_IDLE;
                end else if ((nx < NIL) && (ns < LW'(DEPTH))) begin
                    rd_addr = AW'(nx);
                    n_x     = nx;
                    n_steps = ns;
                end else begin
                    n_rsp.status = (r_req.req_type == REQ_READ) ? ST_NO_TAG : ST_OK;
                    n_done       = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // counts ride on every result beat
        n_rsp.free_count = 7'(n_free_total);
        n_rsp.used_count = 7'(LW'(DEPTH) - n_free_total);
    end

`ifndef NO_ASSERTIONS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_total <= LW'(DEPTH))
        else $error("free total above depth");

    a_no_beat_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |=> !o_done)
        else $error("result beat during init sweep");

    a_walk_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FCHK || r_state == S_TAG) |-> (r_steps < LW'(DEPTH)))
        else $error("walk ran past depth");

    a_walk_ends_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_INIT) ##1 (r_state == S_IDLE) |-> o_done)
        else $error("walk ended without a result beat");
`endif

endmodule
`default_nettype wire

// ===== hdl/lfla_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lfla_mem #(
    parameter int DEPTH      = 64,
    parameter int TAG_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    input  wire logic                         i_link_we,
    input  wire logic [$clog2(DEPTH)-1:0]     i_link_wa,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_link_wd,
    input  wire logic                         i_tag_we,
    input  wire logic [$clog2(DEPTH)-1:0]     i_tag_wa,
    input  wire logic [TAG_BITS-1:0]          i_tag_wd,
    input  wire logic                         i_val_we,
    input  wire logic [$clog2(DEPTH)-1:0]     i_val_wa,
    input  wire logic [VALUE_BITS-1:0]        i_val_wd,
    output logic      [$clog2(DEPTH+1)-1:0]   o_link,
    output logic      [TAG_BITS-1:0]          o_tag,
    output logic      [VALUE_BITS-1:0]        o_val
);

    localparam int LW = $clog2(DEPTH + 1);

    logic [LW-1:0]         mem_link [DEPTH];
    logic [TAG_BITS-1:0]   mem_tag  [DEPTH];
    logic [VALUE_BITS-1:0] mem_val  [DEPTH];

    // one shared read address, registered read data on all three arrays
    always_ff @(posedge i_clk) begin
        if (i_link_we) begin
            mem_link[i_link_wa] <= i_link_wd;
        end
        o_link <= mem_link[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            mem_tag[i_tag_wa] <= i_tag_wd;
        end
        o_tag <= mem_tag[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            mem_val[i_val_wa] <= i_val_wd;
        end
        o_val <= mem_val[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== sim/linked_free_list_allocator_core_tb.sv =====
`timescale 1ns / 1ps
module linked_free_list_allocator_core_tb;
    import lfla_pkg::*;

    localparam int         NODES       = C_DEPTH;
    localparam logic [6:0] NULL_LINK   = 7'(NODES);
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;
    localparam int         RAND_ITEMS  = 1600;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         DRAIN_WAIT  = 2 * NODES + 16;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_req i_req;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    linked_free_list_allocator_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Shadow copy of the node store, used to work out every answer.
    logic [6:0]  link_mem [NODES];
    logic [15:0] tag_mem  [NODES];
    logic [31:0] val_mem  [NODES];
    bit          tag_set  [NODES];
    logic [6:0]  fl_head;
    logic [6:0]  fl_total;
    bit          run_open;
    logic [5:0]  run_head;

    t_rsp        rsp_pending [$];
    logic [5:0]  chain_heads [$];
    int          err_cnt;
    int          cyc_cnt;

    typedef struct packed {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    function automatic t_req mk_req(logic [2:0] kind, logic [5:0] a, logic [15:0] t,
                                    logic [31:0] v, logic lst);
        t_req r;
        r.req_type = kind;
        r.addr     = a;
        r.tag      = t;
        r.value    = v;
        r.last_tag = lst;
        return r;
    endfunction

    function automatic t_rsp mk_rsp(logic [5:0] h, logic [31:0] rv, logic [6:0] fc,
                                    logic isf, logic [1:0] st);
        t_rsp r;
        r.head_addr  = h;
        r.read_value = rv;
        r.free_count = fc;
        r.used_count = 7'(NODES) - fc;
        r.is_free    = isf;
        r.status     = st;
        return r;
    endfunction

    function automatic bit is_on_free_list(logic [6:0] a);
        logic [6:0] x;
        x = fl_head;
        for (int s = 0; s < NODES && x < NULL_LINK; s++) begin
            if (x == a) return 1'b1;
            x = link_mem[x];
        end
        return 1'b0;
    endfunction

    // A tag walk must never compare against a node that was never allocated.
    function automatic bit tag_walk_safe(t_req r);
        logic [6:0] x;
        x = 7'(r.addr);
        for (int s = 0; s < NODES && x < NULL_LINK; s++) begin
            if (!tag_set[x]) return 1'b0;
            if (r.req_type == REQ_READ && tag_mem[x] == r.tag) return 1'b1;
            x = link_mem[x];
        end
        return 1'b1;
    endfunction

    function automatic void reset_store();
        for (int i = 0; i < NODES; i++) begin
            link_mem[i] = 7'(i + 1);
            tag_mem[i]  = '0;
            val_mem[i]  = '0;
            tag_set[i]  = 1'b0;
        end
        fl_head  = '0;
        fl_total = 7'(NODES);
        run_open = 1'b0;
        run_head = '0;
    endfunction

    // Apply one request beat to the shadow store and return its answer.
    function automatic t_rsp apply_request(t_req r);
        t_rsp       o;
        logic [6:0] x;
        logic [6:0] n;
        int         len;
        bit         hit;
        o = '0;
        if (r.req_type == REQ_ALLOC) begin
            if (fl_head >= NULL_LINK) begin
                o.head_addr = run_open ? run_head : '0;
                run_open    = 1'b0;
                o.status    = ST_OOM;
            end else begin
                n = fl_head;
                tag_mem[n] = r.tag;
                tag_set[n] = 1'b1;
                fl_head    = link_mem[n];
                if (fl_total > 0) fl_total--;
                if (!run_open) begin
                    run_head = n[5:0];
                    run_open = 1'b1;
                end
                o.head_addr = run_head;
                if (r.last_tag) begin
                    link_mem[n] = NULL_LINK;
                    run_open    = 1'b0;
                    o.status    = ST_OK;
                end else begin
                    o.status = ST_PENDING;
                end
            end
        end else if (run_open) begin
            o.status = ST_PENDING;
        end else if (r.req_type == REQ_FREE) begin
            if (!is_on_free_list(7'(r.addr))) begin
                x   = 7'(r.addr);
                len = 1;
                for (int s = 0; link_mem[x] < NULL_LINK && s < NODES; s++) begin
                    x = link_mem[x];
                    len++;
                end
                if (link_mem[x] >= NULL_LINK) begin
                    link_mem[x] = fl_head;
                    fl_head     = 7'(r.addr);
                    len         = len + fl_total;
                    fl_total    = (len > NODES) ? 7'(NODES) : 7'(len);
                end
            end
        end else if (r.req_type == REQ_QUERY) begin
            o.is_free = is_on_free_list(7'(r.addr));
        end else if (r.req_type == REQ_WRITE || r.req_type == REQ_READ) begin
            hit = 1'b0;
            x   = 7'(r.addr);
            for (int s = 0; s < NODES && x < NULL_LINK && !hit; s++) begin
                if (tag_mem[x] == r.tag) begin
                    if (r.req_type == REQ_WRITE) begin
                        val_mem[x] = r.value;
                    end else begin
                        o.read_value = val_mem[x];
                        hit = 1'b1;
                    end
                end
                if (!hit) x = link_mem[x];
            end
            if (r.req_type == REQ_READ && !hit) o.status = ST_NO_TAG;
        end
        o.free_count = fl_total;
        o.used_count = 7'(NODES) - fl_total;
        return o;
    endfunction

    // Drive one beat, hold it until the block takes it, then log the answer.
    task automatic issue(t_req r, bit typed, t_rsp want);
        t_rsp calc;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        calc = apply_request(r);
        if (r.req_type == REQ_ALLOC && calc.status != ST_PENDING
            && calc.status != ST_OOM)
            chain_heads.push_back(calc.head_addr);
        if (calc.status == ST_OOM && run_head == calc.head_addr)
            chain_heads.push_back(calc.head_addr);
        rsp_pending.push_back(typed ? want : calc);
    endtask

    // Sender gap: drop start only when the drawn gap is not zero.
    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_tag();
        case ($urandom_range(0, 3))
            0:       return 16'($urandom);
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 3));
        endcase
    endfunction

    // Check each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rsp_pending.size() == 0) begin
                $error("result beat with no request outstanding");
                err_cnt++;
            end else begin
                automatic t_rsp w = rsp_pending.pop_front();
                if (o_rsp.head_addr !== w.head_addr) begin
                    $error("head_addr exp %0d got %0d", w.head_addr, o_rsp.head_addr);
                    err_cnt++;
                end
                if (o_rsp.read_value !== w.read_value) begin
                    $error("read_value exp %0d got %0d", w.read_value, o_rsp.read_value);
                    err_cnt++;
                end
                if (o_rsp.free_count !== w.free_count) begin
                    $error("free_count exp %0d got %0d", w.free_count, o_rsp.free_count);
                    err_cnt++;
                end
                if (o_rsp.used_count !== w.used_count) begin
                    $error("used_count exp %0d got %0d", w.used_count, o_rsp.used_count);
                    err_cnt++;
                end
                if (o_rsp.is_free !== w.is_free) begin
                    $error("is_free exp %0d got %0d", w.is_free, o_rsp.is_free);
                    err_cnt++;
                end
                if (o_rsp.status !== w.status) begin
                    $error("status exp %0d got %0d", w.status, o_rsp.status);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: bail out if the block hangs.
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt > CYCLE_LIMIT) begin
            $display("linked_free_list_allocator_core_tb: done, errors");
            $finish;
        end
    end

    t_row dir_rows [20];

    initial begin
        t_req r;
        int   run_len;
        int   k;
        bit   drained;
        err_cnt = 0;
        cyc_cnt = 0;
        drained = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        i_rst_n = 1'b0;
        reset_store();

        // Directed beats: counts after reset, an alloc run, tag extremes,
        // a run interrupted by other requests, misses, spare codes, frees.
        dir_rows[0]  = '{mk_req(REQ_COUNT, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 64, 0, ST_OK)};
        dir_rows[1]  = '{mk_req(REQ_QUERY, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 64, 1, ST_OK)};
        dir_rows[2]  = '{mk_req(REQ_QUERY, 63, 0, 0, 0), 1'b1, mk_rsp(0, 0, 64, 1, ST_OK)};
        dir_rows[3]  = '{mk_req(REQ_ALLOC, 0, 16'h0000, 0, 0), 1'b1,
                         mk_rsp(0, 0, 63, 0, ST_PENDING)};
        dir_rows[4]  = '{mk_req(REQ_COUNT, 0, 0, 0, 0), 1'b1,
                         mk_rsp(0, 0, 63, 0, ST_PENDING)};
        dir_rows[5]  = '{mk_req(REQ_READ, 0, 0, 0, 0), 1'b1,
                         mk_rsp(0, 0, 63, 0, ST_PENDING)};
        dir_rows[6]  = '{mk_req(REQ_ALLOC, 63, 16'hFFFF, 32'hFFFF_FFFF, 1), 1'b1,
                         mk_rsp(0, 0, 62, 0, ST_OK)};
        dir_rows[7]  = '{mk_req(REQ_READ, 0, 16'h1234, 0, 0), 1'b1,
                         mk_rsp(0, 0, 62, 0, ST_NO_TAG)};
        dir_rows[8]  = '{mk_req(REQ_WRITE, 0, 16'h0000, 32'h8000_0000, 0), 1'b0, '0};
        dir_rows[9]  = '{mk_req(REQ_WRITE, 0, 16'hFFFF, 32'h7FFF_FFFF, 1), 1'b0, '0};
        dir_rows[10] = '{mk_req(REQ_READ, 0, 16'h0000, 0, 0), 1'b1,
                         mk_rsp(0, 32'h8000_0000, 62, 0, ST_OK)};
        dir_rows[11] = '{mk_req(REQ_READ, 1, 16'hFFFF, 0, 0), 1'b1,
                         mk_rsp(0, 32'h7FFF_FFFF, 62, 0, ST_OK)};
        dir_rows[12] = '{mk_req(REQ_QUERY, 1, 0, 0, 0), 1'b1, mk_rsp(0, 0, 62, 0, ST_OK)};
        dir_rows[13] = '{mk_req(REQ_SPARE_A, 63, 16'hFFFF, 32'hFFFF_FFFF, 1), 1'b1,
                         mk_rsp(0, 0, 62, 0, ST_OK)};
        dir_rows[14] = '{mk_req(REQ_SPARE_B, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 62, 0, ST_OK)};
        dir_rows[15] = '{mk_req(REQ_FREE, 5, 0, 0, 0), 1'b1, mk_rsp(0, 0, 62, 0, ST_OK)};
        dir_rows[16] = '{mk_req(REQ_FREE, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 64, 0, ST_OK)};
        dir_rows[17] = '{mk_req(REQ_QUERY, 1, 0, 0, 0), 1'b1, mk_rsp(0, 0, 64, 1, ST_OK)};
        dir_rows[18] = '{mk_req(REQ_ALLOC, 0, 16'h00A5, 0, 1), 1'b0, '0};
        dir_rows[19] = '{mk_req(REQ_FREE, 63, 0, 0, 0), 1'b0, '0};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);
            idle_gap();
        end
        chain_heads.delete();

        // Random phase: mostly well-formed alloc runs and operations on live
        // chains, with noise beats and runs long enough to exhaust the store.
        k = 0;
        while (k < RAND_ITEMS) begin
            if (!drained && k >= RAND_ITEMS / 2) begin
                // Hold off until every outstanding answer has come back.
                drained = 1'b1;
                @(negedge i_clk);
                start <= 1'b0;
                wait (rsp_pending.size() == 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    run_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 70)
                                                          : $urandom_range(1, 6);
                    for (int j = 0; j < run_len; j++) begin
                        r = mk_req(REQ_ALLOC, 6'($urandom), pick_tag(), $urandom,
                                   j == run_len - 1);
                        issue(r, 1'b0, '0);
                        idle_gap();
                        k++;
                    end
                end
                3, 4: begin
                    r = mk_req(REQ_FREE, 6'($urandom), 0, $urandom, 1'($urandom));
                    if (chain_heads.size() > 0 && $urandom_range(0, 3) != 0) begin
                        r.addr = chain_heads[0];
                        void'(chain_heads.pop_front());
                    end
                    issue(r, 1'b0, '0);
                    idle_gap();
                    k++;
                end
                default: begin
                    r = mk_req(3'($urandom_range(1, 7)), 6'($urandom), pick_tag(),
                               $urandom, 1'($urandom));
                    if (chain_heads.size() > 0 && $urandom_range(0, 1) == 0)
                        r.addr = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
                    if ((r.req_type == REQ_WRITE || r.req_type == REQ_READ)
                        && !run_open && !tag_walk_safe(r))
                        r.req_type = REQ_COUNT;
                    issue(r, 1'b0, '0);
                    idle_gap();
                    k++;
                end
            endcase
        end

        @(negedge i_clk);
        start <= 1'b0;
        wait (rsp_pending.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (err_cnt == 0 && rsp_pending.size() == 0) begin
            $display("linked_free_list_allocator_core_tb: done, clean");
        end else begin
            $display("linked_free_list_allocator_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== linked_free_list_allocator_core.f =====
hdl/lfla_pkg.sv
hdl/lfla_mem.sv
hdl/linked_free_list_allocator_core.sv
sim/linked_free_list_allocator_core_tb.sv
